// ===== rtl/core/gray_bit_field_packer_unit_macros.svh =====
// Assertion macros used by the packer RTL.
`ifndef GRAY_BIT_FIELD_PACKER_UNIT_MACROS_SVH
`define GRAY_BIT_FIELD_PACKER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GBFP_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define GBFP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/gbfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gbfp_pkg;

  localparam int FIELD_VALUE_W = 32;
  localparam int FIELD_WIDTH_W = 6;
  localparam int BYTE_W        = 8;
  localparam int IN_TDATA_W    = 40;
  localparam int FIFO_DEPTH    = 2;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last_of_run;
    logic              frame_last;
  } gbfp_beat_t;

endpackage
`default_nettype wire

// ===== rtl/core/gbfp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gbfp_front #(
  parameter int MAX_FIELD_WIDTH = 32,
  parameter int WID_W           = 6
) (
  input  wire logic [gbfp_pkg::FIELD_VALUE_W-1:0] field_value,
  input  wire logic [gbfp_pkg::FIELD_WIDTH_W-1:0] field_width,
  output logic      [MAX_FIELD_WIDTH-1:0]         coded_value,
  output logic      [WID_W-1:0]                   coded_width
);
  import gbfp_pkg::*;

  logic [FIELD_WIDTH_W-1:0] w_sat;
  logic [FIELD_WIDTH_W-1:0] shamt;
  logic [FIELD_VALUE_W-1:0] aligned;
  logic [FIELD_VALUE_W-1:0] mask;
  logic [FIELD_VALUE_W-1:0] coded;

  // The field is left aligned first, so the shift drops the unused upper bits.
  // Gray coding is then done in place and the bit that slid below the field is
  // masked off again.
  always_comb begin
    w_sat   = (field_width > FIELD_WIDTH_W'(MAX_FIELD_WIDTH)) ?
              FIELD_WIDTH_W'(MAX_FIELD_WIDTH) : field_width;
    shamt   = FIELD_WIDTH_W'(FIELD_VALUE_W) - w_sat;
    aligned = field_value << shamt;
    mask    = {FIELD_VALUE_W{1'b1}} << shamt;
    if (w_sat > FIELD_WIDTH_W'(1)) begin
      coded = (aligned ^ (aligned >> 1)) & mask;
    end else begin
      coded = aligned;
    end
    coded_value = coded[FIELD_VALUE_W-1 -: MAX_FIELD_WIDTH];
    coded_width = WID_W'(w_sat);
  end

endmodule
`default_nettype wire

// ===== rtl/core/gbfp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gbfp_fifo #(
  parameter int DATA_W = 39
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output logic      [DATA_W-1:0] pop_data
);
  import gbfp_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [DATA_W-1:0] entries [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(FIFO_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        entries[wr_ptr] <= push_data;
        wr_ptr          <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/gbfp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gbfp_back #(
  parameter int MAX_FIELD_WIDTH = 32,
  parameter int WID_W           = 6
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       pop_valid,
  output logic                            pop_ready,
  input  wire logic [MAX_FIELD_WIDTH-1:0] pop_value,
  input  wire logic [WID_W-1:0]           pop_width,
  input  wire logic                       pop_flush,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output gbfp_pkg::gbfp_beat_t            out_beat,
  output logic                            busy
);
  import gbfp_pkg::*;

  localparam int BUF_W = BYTE_W + MAX_FIELD_WIDTH;
  localparam int CNT_W = $clog2(BUF_W);

  logic [BUF_W-1:0]  bit_buf;
  logic [CNT_W-1:0]  n;
  logic              flush;
  logic [BYTE_W-1:0] partial_byte;
  logic [2:0]        bits_filled;

  logic [BUF_W-1:0]  load_buf;
  logic [CNT_W-1:0]  load_n;
  logic [BUF_W-1:0]  buf_shift;
  logic [CNT_W-1:0]  n_rem;
  logic [BYTE_W-1:0] top_byte;
  logic              emit_last;
  logic              slot_free;

  // The held partial bits sit on top and the new field follows straight after.
  assign load_buf  = {partial_byte, {MAX_FIELD_WIDTH{1'b0}}} |
                     ({pop_value, {BYTE_W{1'b0}}} >> bits_filled);
  assign load_n    = CNT_W'(bits_filled) + CNT_W'(pop_width);
  assign buf_shift = bit_buf << BYTE_W;
  assign n_rem     = n - CNT_W'(BYTE_W);
  assign top_byte  = bit_buf[BUF_W-1 -: BYTE_W];
  assign emit_last = (n_rem < CNT_W'(BYTE_W)) && !(flush && (n_rem != '0));
  assign slot_free = !out_valid || out_ready;
  assign pop_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      out_valid    <= 1'b0;
      out_beat     <= '0;
      bit_buf      <= '0;
      n            <= '0;
      flush        <= 1'b0;
      partial_byte <= '0;
      bits_filled  <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (!busy) begin
        if (pop_valid) begin
          bit_buf <= load_buf;
          n       <= load_n;
          flush   <= pop_flush;
          busy    <= 1'b1;
        end
      end else if (slot_free) begin
        if (n >= CNT_W'(BYTE_W)) begin
          out_valid            <= 1'b1;
          out_beat.data        <= top_byte;
          out_beat.last_of_run <= emit_last;
          out_beat.frame_last  <= emit_last && flush;
          bit_buf              <= buf_shift;
          n                    <= n_rem;
          if (emit_last) begin
            busy         <= 1'b0;
            partial_byte <= buf_shift[BUF_W-1 -: BYTE_W];
            bits_filled  <= n_rem[2:0];
          end
        end else if (flush && (n != '0)) begin
          // Flush of a partial byte: the bits below it are already zero.
          out_valid            <= 1'b1;
          out_beat.data        <= top_byte;
          out_beat.last_of_run <= 1'b1;
          out_beat.frame_last  <= 1'b1;
          busy                 <= 1'b0;
          partial_byte         <= '0;
          bits_filled          <= '0;
        end else begin
          busy         <= 1'b0;
          partial_byte <= top_byte;
          bits_filled  <= n[2:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/gray_bit_field_packer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// MSB-first bit packer: each input beat carries a field of 1 to 32 bits (wider
// codes saturate to MAX_FIELD_WIDTH, zero appends nothing), multi-bit fields are
// Gray coded, and the bits are packed into bytes with the first bit in bit 7.
// tlast on an input beat flushes a partial byte zero padded; the last byte
// caused by an input beat carries m_tlast, and m_tuser marks the final byte of
// a flushed frame. An input beat that completes no byte produces no output.
// The front end codes and aligns fields into a two-entry queue; the back end
// takes one entry, merges it with the held partial byte in its bit buffer and
// then emits one byte per cycle while m_tready does not stall it. It takes no
// new entry until it has finished with the last one.
module gray_bit_field_packer_unit #(
  parameter int MAX_FIELD_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // field_value[31:0], field_width[37:32], zero pad
  input  wire logic        s_tlast,   // frame_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,   // out_byte[7:0]
  output logic             m_tlast,   // last_of_run
  output logic             m_tuser    // frame_last
);
  import gbfp_pkg::*;

`include "gray_bit_field_packer_unit_macros.svh"

  localparam int WID_W   = $clog2(MAX_FIELD_WIDTH + 1);
  localparam int ENTRY_W = MAX_FIELD_WIDTH + WID_W + 1;

  logic [MAX_FIELD_WIDTH-1:0] front_value;
  logic [WID_W-1:0]           front_width;
  logic [ENTRY_W-1:0]         push_data;
  logic [ENTRY_W-1:0]         pop_data;
  logic                       pop_valid;
  logic                       pop_ready;
  logic                       back_busy;
  gbfp_beat_t                 beat;

  gbfp_front #(
    .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH),
    .WID_W          (WID_W)
  ) u_front (
    .field_value(s_tdata[FIELD_VALUE_W-1:0]),
    .field_width(s_tdata[FIELD_VALUE_W +: FIELD_WIDTH_W]),
    .coded_value(front_value),
    .coded_width(front_width)
  );

  assign push_data = {s_tlast, front_width, front_value};

  gbfp_fifo #(
    .DATA_W(ENTRY_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(s_tvalid),
    .push_ready(s_tready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  gbfp_back #(
    .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH),
    .WID_W          (WID_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_value(pop_data[MAX_FIELD_WIDTH-1:0]),
    .pop_width(pop_data[MAX_FIELD_WIDTH +: WID_W]),
    .pop_flush(pop_data[ENTRY_W-1]),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_beat (beat),
    .busy     (back_busy)
  );

  assign m_tdata = beat.data;
  assign m_tlast = beat.last_of_run;
  assign m_tuser = beat.frame_last;

  `GBFP_ASSERT_IMPLIES(a_frame_last_ends_run, clk, rst, m_tvalid && m_tuser, m_tlast, "frame_last without last_of_run")
  `GBFP_ASSERT_IMPLIES(a_mid_run_keeps_busy, clk, rst, m_tvalid && !m_tlast, back_busy, "back end idle in the middle of a run")
  `GBFP_ASSERT_NEXT(a_accept_queues_item, clk, rst, s_tvalid && s_tready, pop_valid || back_busy, "accepted beat lost before the back end")

endmodule
`default_nettype wire

// ===== sim/gbfp_pack_checker.sv =====
`timescale 1ns / 1ps
module gbfp_pack_checker #(
  parameter int MAX_FIELD_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [gbfp_pkg::IN_TDATA_W-1:0] s_tdata,   // field_value[31:0], field_width[37:32], zero pad
  input  logic                            s_tlast,   // frame_end
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [gbfp_pkg::BYTE_W-1:0]     m_tdata,   // out_byte[7:0]
  input  logic                            m_tlast,   // last_of_run
  input  logic                            m_tuser,   // frame_last
  output int                              expected_left,
  output int                              error_count
);
  import gbfp_pkg::*;

  logic [BYTE_W-1:0] packed_bits;
  logic [2:0]        bits_filled;
  gbfp_beat_t        expected_bytes[$];
  int                errors = 0;

  // Appends one field MSB first and queues every byte it completes.
  task automatic pack_field(input logic [IN_TDATA_W-1:0] beat, input logic flush);
    logic [FIELD_VALUE_W-1:0] value;
    logic [63:0]              mask;
    int                       width;
    int                       n;
    gbfp_beat_t               run[5];
    width = int'(beat[FIELD_VALUE_W +: FIELD_WIDTH_W]);
    if (width > MAX_FIELD_WIDTH) width = MAX_FIELD_WIDTH;
    mask  = (64'd1 << width) - 64'd1;
    value = beat[FIELD_VALUE_W-1:0] & mask[FIELD_VALUE_W-1:0];
    if (width > 1) value = value ^ (value >> 1);
    n = 0;
    for (int i = width; i > 0; i--) begin
      packed_bits[3'd7 - bits_filled] = value[i-1];
      bits_filled = bits_filled + 3'd1;
      if (bits_filled == 3'd0) begin
        run[n] = '{data: packed_bits, last_of_run: 1'b0, frame_last: 1'b0};
        n++;
        packed_bits = '0;
      end
    end
    if (flush && bits_filled != 3'd0) begin
      run[n] = '{data: packed_bits, last_of_run: 1'b0, frame_last: 1'b0};
      n++;
      packed_bits = '0;
      bits_filled = '0;
    end
    if (n > 0) begin
      run[n-1].last_of_run = 1'b1;
      run[n-1].frame_last  = flush;
    end
    for (int k = 0; k < n; k++) expected_bytes.push_back(run[k]);
  endtask

  always @(posedge clk) begin
    gbfp_beat_t want;
    if (rst) begin
      packed_bits = '0;
      bits_filled = '0;
      expected_bytes.delete();
    end else begin
      // An output beat can never stem from an input taken on the same edge.
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected output beat: data %h last %b user %b", m_tdata, m_tlast, m_tuser);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (m_tdata !== want.data) begin
            $error("out_byte: expected %h, actual %h", want.data, m_tdata);
            errors++;
          end
          if (m_tlast !== want.last_of_run) begin
            $error("last_of_run: expected %b, actual %b", want.last_of_run, m_tlast);
            errors++;
          end
          if (m_tuser !== want.frame_last) begin
            $error("frame_last: expected %b, actual %b", want.frame_last, m_tuser);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) pack_field(s_tdata, s_tlast);
    end
    expected_left <= expected_bytes.size();
    error_count   <= errors;
  end

endmodule

// ===== sim/gray_bit_field_packer_unit_tb.sv =====
`timescale 1ns / 1ps
module gray_bit_field_packer_unit_tb;
  import gbfp_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata  = '0;   // field_value[31:0], field_width[37:32], zero pad
  logic                  s_tlast  = 1'b0; // frame_end
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [BYTE_W-1:0]     m_tdata;         // out_byte[7:0]
  logic                  m_tlast;         // last_of_run
  logic                  m_tuser;         // frame_last

  int expected_left;
  int error_count;
  int idle_cycles = 0;
  bit no_gaps     = 1'b0;

  always #6 clk = ~clk;

  gray_bit_field_packer_unit #(.MAX_FIELD_WIDTH(32)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  gbfp_pack_checker #(.MAX_FIELD_WIDTH(32)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .expected_left(expected_left), .error_count(error_count)
  );

  // The watchdog only counts edges at which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("gray_bit_field_packer_unit: mismatch");
        $finish;
      end
    end
  end

  // Byte sink: stalls a random number of cycles before each output beat.
  initial begin
    int gap;
    wait (rst == 1'b0);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send_field(input logic [31:0] value, input logic [5:0] width,
                            input logic frame_end);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {2'b00, width, value};
    s_tlast  <= frame_end;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_random_field();
    int          pick;
    logic [5:0]  width;
    pick = $urandom_range(0, 19);
    if (pick == 0)      width = 6'd0;
    else if (pick <= 2) width = 6'($urandom_range(33, 63));
    else if (pick <= 5) width = 6'd32;
    else                width = 6'($urandom_range(1, 32));
    send_field($urandom(), width, $urandom_range(0, 5) == 0);
  endtask

  // Holds the sender off until every queued byte has been taken.
  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-bit fields bypass Gray coding; the third also checks masking.
    send_field(32'h0000_0000, 6'd1, 1'b0);
    send_field(32'h0000_0001, 6'd1, 1'b0);
    send_field(32'hFFFF_FFFF, 6'd1, 1'b0);
    send_field(32'h0000_0005, 6'd3, 1'b0);
    send_field(32'h0000_0000, 6'd2, 1'b1);
    send_field(32'hFFFF_FFFF, 6'd32, 1'b0);
    send_field(32'h0000_0000, 6'd32, 1'b0);
    // Byte aligned end of frame: the last full byte carries the frame mark.
    send_field(32'h8000_0000, 6'd32, 1'b1);
    // Flush with nothing pending yields no beat at all.
    send_field(32'hFFFF_FFFF, 6'd0, 1'b1);
    send_field(32'h0000_0003, 6'd2, 1'b0);
    send_field(32'hFFFF_FFFF, 6'd0, 1'b1);
    send_field(32'hFFFF_FFFF, 6'd0, 1'b0);
    // Widths above the maximum saturate.
    send_field(32'hFFFF_FFFF, 6'd33, 1'b0);
    send_field(32'h1234_5678, 6'd63, 1'b1);
    send_field(32'h0000_00AB, 6'd8, 1'b1);
    send_field(32'h5555_AAAA, 6'd31, 1'b0);
    send_field(32'hFFFF_FFFF, 6'd7, 1'b0);
    send_field(32'h0000_0001, 6'd1, 1'b1);
    send_field(32'hDEAD_BEEF, 6'd40, 1'b0);
    send_field(32'h0000_0000, 6'd5, 1'b1);
    drain_outputs();

    for (int phase = 0; phase < 6; phase++) begin
      no_gaps = (phase % 3 == 1);
      for (int n = 0; n < 25; n++) send_random_field();
      if (phase % 2 == 0) drain_outputs();
    end
    no_gaps = 1'b0;
    send_field($urandom(), 6'd32, 1'b1);

    drain_outputs();
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_left == 0) begin
      $display("gray_bit_field_packer_unit: match");
    end else begin
      $display("gray_bit_field_packer_unit: mismatch");
    end
    $finish;
  end

endmodule
